@@ rtl/mhcc_pkg.sv @@
// ----------------------------------------------------------------------------
// mhcc_pkg: shared types and constants for the median hsv colour classifier
// Histogram sizes, register map, colour codes and the controller states.
// ----------------------------------------------------------------------------
package mhcc_pkg;

    localparam int MAX_PATCH_PIXELS = 65536;
    localparam int CNT_W            = $clog2(MAX_PATCH_PIXELS + 1);
    localparam int HUE_BINS         = 180;
    localparam int SV_BINS          = 256;
    localparam int NUM_REGS         = 8;
    localparam int ADDR_W           = $clog2(NUM_REGS) + 2;

    typedef logic [CNT_W-1:0] count_t;

    // input kinds
    localparam logic [1:0] KIND_PIXEL = 2'd0;
    localparam logic [1:0] KIND_FINAL = 2'd1;
    localparam logic [1:0] KIND_EMPTY = 2'd2;

    // register indexes
    typedef enum logic [2:0] {
        REG_RED_LOW_TOP     = 3'd0,
        REG_ORANGE_TOP      = 3'd1,
        REG_YELLOW_TOP      = 3'd2,
        REG_GREEN_TOP       = 3'd3,
        REG_BLUE_TOP        = 3'd4,
        REG_RED_HIGH_BOTTOM = 3'd5,
        REG_WHITE_SAT_LIMIT = 3'd6,
        REG_DARK_LIMIT      = 3'd7
    } reg_idx_t;

    function automatic logic [7:0] reg_reset_value(input reg_idx_t idx);
        logic [7:0] val;
        unique case (idx)
            REG_RED_LOW_TOP:     val = 8'd10;
            REG_ORANGE_TOP:      val = 8'd25;
            REG_YELLOW_TOP:      val = 8'd35;
            REG_GREEN_TOP:       val = 8'd85;
            REG_BLUE_TOP:        val = 8'd130;
            REG_RED_HIGH_BOTTOM: val = 8'd160;
            REG_WHITE_SAT_LIMIT: val = 8'd90;
            REG_DARK_LIMIT:      val = 8'd50;
            default:             val = 8'd0;
        endcase
        return val;
    endfunction

    // colour codes
    localparam logic [2:0] COL_UNKNOWN = 3'd0;
    localparam logic [2:0] COL_WHITE   = 3'd1;
    localparam logic [2:0] COL_RED     = 3'd2;
    localparam logic [2:0] COL_ORANGE  = 3'd3;
    localparam logic [2:0] COL_YELLOW  = 3'd4;
    localparam logic [2:0] COL_GREEN   = 3'd5;
    localparam logic [2:0] COL_BLUE    = 3'd6;

    localparam logic [7:0] VAL_NORM    = 8'd149;
    localparam logic [7:0] SAT_BOOST_LIMIT = 8'd50;
    localparam logic [7:0] WHITE_VAL_MIN   = 8'd120;
    localparam logic [7:0] HUE_MAX         = 8'd179;

    typedef enum logic [3:0] {
        ST_SETUP,
        ST_WALK,
        ST_DRAIN,
        ST_EMIT,
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_RD,
        ST_WR
    } state_t;

endpackage

@@ rtl/median_hsv_colour_classifier_top.sv @@
// ----------------------------------------------------------------------------
// median_hsv_colour_classifier_top: patch colour classifier
// Converts BGR pixels to HSV, builds per-channel histograms in block memory,
// walks them for the medians and classifies the patch colour.
// ----------------------------------------------------------------------------
// usage:
//   s_ channel takes one word per pixel (kind, blue, green, red). kind 0 adds
//   a pixel, kind 1 adds the last pixel and produces a result, kind 2 ends an
//   empty patch and produces unknown with zero medians, kind 3 is dropped.
//   m_ channel gives colour and the three medians, one word per patch.
//   a pixel keeps s_ready low after acceptance through a preparation state,
//   the two bit-serial dividers (saturation and hue in parallel), a histogram
//   read and a write-back, so a new pixel is taken only after the last one is
//   written back.
//   a final pixel adds a setup state, a walk over the histogram memories
//   (one bin per cycle, which also clears them), a drain state and the load
//   of the output register. after reset the same walk clears the memories:
//   s_ready is low until it ends. configuration writes are taken at any time,
//   but a write while a patch is in flight changes how that patch is
//   classified.
//   the output register holds its word while m_ready is low; new pixels keep
//   being accepted until the next result is ready; it then waits with s_ready low.
// ----------------------------------------------------------------------------
module median_hsv_colour_classifier_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [7:0]  s_blue,
    input  logic [7:0]  s_green,
    input  logic [7:0]  s_red,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_colour,
    output logic [7:0]  m_median_hue,
    output logic [7:0]  m_median_sat,
    output logic [7:0]  m_median_val,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [mhcc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mhcc_pkg::*;

    // configuration registers
    logic [7:0] cfg_reg [NUM_REGS];
    logic [2:0] cfg_idx;

    assign cfg_idx = paddr[ADDR_W-1:2];
    assign pready  = 1'b1;
    assign prdata  = {24'd0, cfg_reg[cfg_idx]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                cfg_reg[i] <= reg_reset_value(reg_idx_t'(3'(i)));
            end
        end else if (psel && penable && pwrite) begin
            cfg_reg[cfg_idx] <= pwdata[7:0];
        end
    end

    // controller
    state_t state_reg, state_next;
    logic [1:0] kind_reg;
    logic [7:0] pix_b_reg, pix_g_reg, pix_r_reg;
    logic       emit_reg, zero_reg;
    count_t     count_reg, target_reg;
    logic [8:0] walk_addr_reg;
    logic [2:0] div_step_reg;

    // divider state
    logic [16:0] rem_s_reg, rem_h_reg;
    logic [15:0] dsh_s_reg, dsh_h_reg;
    logic [7:0]  q_s_reg, q_h_reg;
    logic        zero_s_reg, zero_h_reg;
    logic [7:0]  mx_reg;

    logic accept;
    logic full;
    logic out_free;

    assign accept   = s_valid && s_ready;
    assign full     = count_reg >= CNT_W'(MAX_PATCH_PIXELS);
    assign out_free = !m_valid || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_SETUP: state_next = ST_WALK;
            ST_WALK:  if (walk_addr_reg[7:0] == 8'd255) state_next = ST_DRAIN;
            ST_DRAIN: state_next = ST_EMIT;
            ST_EMIT:  if (!emit_reg || out_free) state_next = ST_IDLE;
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_kind == KIND_PIXEL || s_kind == KIND_FINAL) begin
                        state_next = ST_PREP;
                    end else if (s_kind == KIND_EMPTY) begin
                        state_next = ST_SETUP;
                    end
                end
            end
            ST_PREP:  state_next = ST_DIV;
            ST_DIV:   if (div_step_reg == 3'd7) state_next = ST_RD;
            ST_RD:    state_next = ST_WR;
            ST_WR:    state_next = (kind_reg == KIND_FINAL) ? ST_SETUP : ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // hsv front end: max, min and the division operands
    logic [7:0]         mx, mn, diff;
    logic signed [11:0] x_raw, x_adj;
    logic [16:0]        num_s, num_h;
    logic [8:0]         den_s, den_h;

    always_comb begin
        mx = pix_b_reg;
        mn = pix_b_reg;
        if (pix_g_reg > mx) mx = pix_g_reg;
        if (pix_r_reg > mx) mx = pix_r_reg;
        if (pix_g_reg < mn) mn = pix_g_reg;
        if (pix_r_reg < mn) mn = pix_r_reg;
        diff = mx - mn;
        if (mx == pix_r_reg) begin
            x_raw = $signed({4'd0, pix_g_reg}) - $signed({4'd0, pix_b_reg});
        end else if (mx == pix_g_reg) begin
            x_raw = $signed({4'd0, pix_b_reg}) - $signed({4'd0, pix_r_reg})
                  + $signed({3'd0, diff, 1'b0});
        end else begin
            x_raw = $signed({4'd0, pix_r_reg}) - $signed({4'd0, pix_g_reg})
                  + $signed({2'd0, diff, 2'b0});
        end
        x_adj = (x_raw < 0) ? x_raw + $signed(12'(diff) * 12'd6) : x_raw;
        num_h = 17'(x_adj[10:0]) * 17'd60 + 17'(diff);
        num_s = 17'(diff) * 17'd510 + 17'(mx);
        den_h = {1'b0, diff} << 1;
        den_s = {1'b0, mx} << 1;
    end

    logic        ge_s, ge_h;
    logic [7:0]  pix_h, pix_s;

    assign ge_s  = rem_s_reg >= {1'b0, dsh_s_reg};
    assign ge_h  = rem_h_reg >= {1'b0, dsh_h_reg};
    assign pix_s = zero_s_reg ? 8'd0 : q_s_reg;
    assign pix_h = (zero_h_reg || q_h_reg > HUE_MAX) ? 8'd0 : q_h_reg;

    // memory control, decoded from the state
    logic [7:0]   sv_rd_addr, h_rd_addr;
    logic [7:0]   s_addr, v_addr;
    logic         mem_we, hue_we;
    logic         walking;
    logic         hue_in_range;
    logic [CNT_W-1:0] hue_q, sat_q, val_q;
    logic [CNT_W-1:0] hue_wd, sat_wd, val_wd;

    always_comb begin
        walking      = state_reg == ST_WALK;
        hue_in_range = walk_addr_reg[7:0] < 8'(HUE_BINS);
        s_addr       = walking ? walk_addr_reg[7:0] : pix_s;
        v_addr       = walking ? walk_addr_reg[7:0] : mx_reg;
        h_rd_addr    = walking ? (hue_in_range ? walk_addr_reg[7:0] : 8'd0) : pix_h;
        sv_rd_addr   = s_addr;
        mem_we       = walking || (state_reg == ST_WR && !full);
        hue_we       = walking ? hue_in_range : (state_reg == ST_WR && !full);
        hue_wd       = walking ? '0 : hue_q + 1'b1;
        sat_wd       = walking ? '0 : sat_q + 1'b1;
        val_wd       = walking ? '0 : val_q + 1'b1;
    end

    // histogram memories, read-first
    logic [CNT_W-1:0] hue_mem [HUE_BINS];
    logic [CNT_W-1:0] sat_mem [SV_BINS];
    logic [CNT_W-1:0] val_mem [SV_BINS];

    always_ff @(posedge aclk) begin
        if (hue_we) hue_mem[h_rd_addr] <= hue_wd;
        hue_q <= hue_mem[h_rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (mem_we) sat_mem[sv_rd_addr] <= sat_wd;
        sat_q <= sat_mem[sv_rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (mem_we) val_mem[v_addr] <= val_wd;
        val_q <= val_mem[v_addr];
    end

    // median walk: accumulate the bin read in the cycle before
    logic             rd_valid_reg, rd_hue_ok_reg;
    logic [7:0]       rd_idx_reg;
    count_t           acc_h_reg, acc_s_reg, acc_v_reg;
    logic             found_h_reg, found_s_reg, found_v_reg;
    logic [7:0]       med_h_reg, med_s_reg, med_v_reg;
    count_t           acc_h_next, acc_s_next, acc_v_next;

    assign acc_h_next = acc_h_reg + (rd_hue_ok_reg ? hue_q : '0);
    assign acc_s_next = acc_s_reg + sat_q;
    assign acc_v_next = acc_v_reg + val_q;

    // classification of the medians
    logic [7:0] vn, s_adj;
    logic [2:0] colour;
    logic [9:0] s_x3;

    always_comb begin
        vn    = (med_v_reg != 8'd0) ? VAL_NORM : 8'd0;
        s_x3  = 10'(med_s_reg) * 10'd3;
        s_adj = (med_s_reg < SAT_BOOST_LIMIT) ? s_x3[8:1] : med_s_reg;
        if (vn < cfg_reg[REG_DARK_LIMIT]) begin
            colour = COL_UNKNOWN;
        end else if (s_adj < cfg_reg[REG_WHITE_SAT_LIMIT] && vn > WHITE_VAL_MIN) begin
            colour = COL_WHITE;
        end else if (med_h_reg <= cfg_reg[REG_RED_LOW_TOP] ||
                     (med_h_reg >= cfg_reg[REG_RED_HIGH_BOTTOM] && med_h_reg <= HUE_MAX)) begin
            colour = COL_RED;
        end else if (med_h_reg > cfg_reg[REG_RED_LOW_TOP] &&
                     med_h_reg <= cfg_reg[REG_ORANGE_TOP]) begin
            colour = COL_ORANGE;
        end else if (med_h_reg > cfg_reg[REG_ORANGE_TOP] &&
                     med_h_reg <= cfg_reg[REG_YELLOW_TOP]) begin
            colour = COL_YELLOW;
        end else if (med_h_reg > cfg_reg[REG_YELLOW_TOP] &&
                     med_h_reg <= cfg_reg[REG_GREEN_TOP]) begin
            colour = COL_GREEN;
        end else if (med_h_reg > cfg_reg[REG_GREEN_TOP] &&
                     med_h_reg <= cfg_reg[REG_BLUE_TOP]) begin
            colour = COL_BLUE;
        end else begin
            colour = COL_UNKNOWN;
        end
    end

    // output register
    logic       m_valid_reg;
    logic [2:0] m_colour_reg;
    logic [7:0] m_hue_reg, m_sat_reg, m_val_reg;
    logic       load_out;

    assign load_out     = state_reg == ST_EMIT && emit_reg && out_free;
    assign s_ready      = state_reg == ST_IDLE;
    assign m_valid      = m_valid_reg;
    assign m_colour     = m_colour_reg;
    assign m_median_hue = m_hue_reg;
    assign m_median_sat = m_sat_reg;
    assign m_median_val = m_val_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_colour_reg <= zero_reg ? COL_UNKNOWN : colour;
            m_hue_reg    <= zero_reg ? 8'd0 : med_h_reg;
            m_sat_reg    <= zero_reg ? 8'd0 : med_s_reg;
            m_val_reg    <= zero_reg ? 8'd0 : med_v_reg;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_SETUP;
            emit_reg     <= 1'b0;
            zero_reg     <= 1'b0;
            count_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rd_valid_reg <= walking;
            if (accept) begin
                emit_reg <= s_kind == KIND_FINAL || s_kind == KIND_EMPTY;
                zero_reg <= s_kind == KIND_EMPTY;
            end
            if (state_reg == ST_SETUP) begin
                count_reg <= '0;
            end else if (state_reg == ST_WR && !full) begin
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg  <= s_kind;
            pix_b_reg <= s_blue;
            pix_g_reg <= s_green;
            pix_r_reg <= s_red;
        end

        // bit-serial restoring division, one quotient bit per cycle
        if (state_reg == ST_PREP) begin
            mx_reg       <= mx;
            rem_s_reg    <= num_s;
            rem_h_reg    <= num_h;
            dsh_s_reg    <= {den_s, 7'd0};
            dsh_h_reg    <= {den_h, 7'd0};
            zero_s_reg   <= mx == 8'd0;
            zero_h_reg   <= diff == 8'd0;
            div_step_reg <= 3'd0;
        end else if (state_reg == ST_DIV) begin
            if (ge_s) rem_s_reg <= rem_s_reg - {1'b0, dsh_s_reg};
            if (ge_h) rem_h_reg <= rem_h_reg - {1'b0, dsh_h_reg};
            q_s_reg      <= {q_s_reg[6:0], ge_s};
            q_h_reg      <= {q_h_reg[6:0], ge_h};
            dsh_s_reg    <= dsh_s_reg >> 1;
            dsh_h_reg    <= dsh_h_reg >> 1;
            div_step_reg <= div_step_reg + 3'd1;
        end

        if (state_reg == ST_SETUP) begin
            target_reg    <= count_reg >> 1;
            walk_addr_reg <= '0;
            acc_h_reg     <= '0;
            acc_s_reg     <= '0;
            acc_v_reg     <= '0;
            found_h_reg   <= 1'b0;
            found_s_reg   <= 1'b0;
            found_v_reg   <= 1'b0;
            med_h_reg     <= '0;
            med_s_reg     <= '0;
            med_v_reg     <= '0;
        end else begin
            if (walking) walk_addr_reg <= walk_addr_reg + 9'd1;
            if (rd_valid_reg) begin
                acc_h_reg <= acc_h_next;
                acc_s_reg <= acc_s_next;
                acc_v_reg <= acc_v_next;
                if (!found_h_reg && acc_h_next > target_reg) begin
                    found_h_reg <= 1'b1;
                    med_h_reg   <= rd_idx_reg;
                end
                if (!found_s_reg && acc_s_next > target_reg) begin
                    found_s_reg <= 1'b1;
                    med_s_reg   <= rd_idx_reg;
                end
                if (!found_v_reg && acc_v_next > target_reg) begin
                    found_v_reg <= 1'b1;
                    med_v_reg   <= rd_idx_reg;
                end
            end
        end

        rd_idx_reg    <= walk_addr_reg[7:0];
        rd_hue_ok_reg <= hue_in_range;
    end

endmodule

@@ sim/tb_median_hsv_colour_classifier_top.sv @@
// ----------------------------------------------------------------------------
// tb_median_hsv_colour_classifier_top: testbench for the patch colour classifier
// Drives pixel words with random gaps, predicts each patch result from its own
// histograms and classifier, and compares results in order with random stalls.
// ----------------------------------------------------------------------------
module tb_median_hsv_colour_classifier_top;
    timeunit 1ns;
    timeprecision 1ps;
    import mhcc_pkg::*;

    typedef struct packed {
        logic [2:0] colour;
        logic [7:0] hue;
        logic [7:0] sat;
        logic [7:0] val;
    } patch_result_t;

    class patch_scoreboard;
        logic [7:0] thresholds [NUM_REGS];
        int unsigned hue_hist [HUE_BINS];
        int unsigned sat_hist [SV_BINS];
        int unsigned val_hist [SV_BINS];
        int unsigned npix;
        patch_result_t pending [$];
        int errors;

        function void init();
            for (int i = 0; i < NUM_REGS; i++) thresholds[i] = reg_reset_value(reg_idx_t'(i));
            clear_patch();
            errors = 0;
        endfunction

        function void clear_patch();
            foreach (hue_hist[i]) hue_hist[i] = 0;
            foreach (sat_hist[i]) sat_hist[i] = 0;
            foreach (val_hist[i]) val_hist[i] = 0;
            npix = 0;
        endfunction

        function void count_pixel(int b, int g, int r);
            int mx, mn, diff, s, h, x;
            mx = b; mn = b;
            if (g > mx) mx = g;
            if (r > mx) mx = r;
            if (g < mn) mn = g;
            if (r < mn) mn = r;
            diff = mx - mn;
            s = (mx == 0) ? 0 : (510 * diff + mx) / (2 * mx);
            h = 0;
            if (diff != 0) begin
                if (mx == r) x = g - b;
                else if (mx == g) x = b - r + 2 * diff;
                else x = r - g + 4 * diff;
                if (x < 0) x += 6 * diff;
                h = (60 * x + diff) / (2 * diff);
                if (h >= HUE_BINS) h = 0;
            end
            if (npix >= MAX_PATCH_PIXELS) return;
            hue_hist[h]++;
            sat_hist[s]++;
            val_hist[mx]++;
            npix++;
        endfunction

        function int median_of(int unsigned hist [], int unsigned n);
            int unsigned acc;
            acc = 0;
            for (int i = 0; i < hist.size(); i++) begin
                acc += hist[i];
                if (acc > n / 2) return i;
            end
            return 0;
        endfunction

        function logic [2:0] classify(int h, int s, int v);
            int vn;
            vn = (v != 0) ? 149 : 0;
            if (s < 50) s = (3 * s) / 2;
            if (vn < thresholds[REG_DARK_LIMIT]) return COL_UNKNOWN;
            if (s < thresholds[REG_WHITE_SAT_LIMIT] && vn > 120) return COL_WHITE;
            if (h <= thresholds[REG_RED_LOW_TOP] ||
                (h >= thresholds[REG_RED_HIGH_BOTTOM] && h <= 179)) return COL_RED;
            if (h <= thresholds[REG_ORANGE_TOP]) return COL_ORANGE;
            if (h > thresholds[REG_ORANGE_TOP] && h <= thresholds[REG_YELLOW_TOP])
                return COL_YELLOW;
            if (h > thresholds[REG_YELLOW_TOP] && h <= thresholds[REG_GREEN_TOP])
                return COL_GREEN;
            if (h > thresholds[REG_GREEN_TOP] && h <= thresholds[REG_BLUE_TOP])
                return COL_BLUE;
            return COL_UNKNOWN;
        endfunction

        function void note_word(logic [1:0] kind, logic [7:0] b, logic [7:0] g, logic [7:0] r);
            patch_result_t res;
            int unsigned hh [], sh [], vh [];
            if (kind == KIND_PIXEL) begin
                count_pixel(b, g, r);
            end else if (kind == KIND_FINAL) begin
                count_pixel(b, g, r);
                hh = hue_hist; sh = sat_hist; vh = val_hist;
                res.hue = 8'(median_of(hh, npix));
                res.sat = 8'(median_of(sh, npix));
                res.val = 8'(median_of(vh, npix));
                res.colour = classify(res.hue, res.sat, res.val);
                pending = {pending, res};
                clear_patch();
            end else if (kind == KIND_EMPTY) begin
                res = '0;
                res.colour = COL_UNKNOWN;
                pending = {pending, res};
                clear_patch();
            end
        endfunction

        function void check_result(patch_result_t act);
            patch_result_t exp_r;
            if (pending.size() == 0) begin
                $error("unexpected result colour=%0d", act.colour);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (act.colour !== exp_r.colour) begin
                $error("colour: expected %0d, actual %0d", exp_r.colour, act.colour);
                errors++;
            end
            if (act.hue !== exp_r.hue) begin
                $error("median_hue: expected %0d, actual %0d", exp_r.hue, act.hue);
                errors++;
            end
            if (act.sat !== exp_r.sat) begin
                $error("median_sat: expected %0d, actual %0d", exp_r.sat, act.sat);
                errors++;
            end
            if (act.val !== exp_r.val) begin
                $error("median_val: expected %0d, actual %0d", exp_r.val, act.val);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_kind;
    logic [7:0]  s_blue, s_green, s_red;
    logic        m_valid;
    logic        m_ready;
    logic [2:0]  m_colour;
    logic [7:0]  m_median_hue, m_median_sat, m_median_val;
    logic        psel, penable, pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0] pwdata, prdata;
    logic        pready;

    patch_scoreboard sb;
    bit          long_stall;
    int          cycles = 0;

    localparam int LIMIT = 3_000_000;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    median_hsv_colour_classifier_top u_dut (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // result side: compare and stall at random
    initial begin
        int gap;
        m_ready = 1'b0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (long_stall) begin
                m_ready <= 1'b0;
                repeat (3000) @(negedge aclk);
                long_stall = 1'b0;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            sb.check_result({m_colour, m_median_hue, m_median_sat, m_median_val});
        end
    end

    task automatic apb_write(reg_idx_t idx, logic [7:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx) << 2;
        pwdata  <= 32'(value);
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.thresholds[idx] = value;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_word(logic [1:0] kind, logic [7:0] b, logic [7:0] g, logic [7:0] r,
                             bit gaps);
        int gap;
        gap = (gaps && $urandom_range(0, 2) == 0) ? $urandom_range(0, 17) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_kind  <= kind;
        s_blue  <= b;
        s_green <= g;
        s_red   <= r;
        do @(posedge aclk); while (!s_ready);
        sb.note_word(kind, b, g, r);
        @(negedge aclk);
    endtask

    task automatic end_word();
        s_valid <= 1'b0;
    endtask

    // wait for every result, then for the block to settle
    task automatic drain();
        end_word();
        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (300) @(negedge aclk);
    endtask

    // patch of pixels around a base colour, ending in a final pixel
    task automatic send_patch(int npx, bit gaps);
        int b0, g0, r0, spread;
        b0 = $urandom_range(0, 255);
        g0 = $urandom_range(0, 255);
        r0 = $urandom_range(0, 255);
        spread = $urandom_range(0, 40);
        for (int i = 0; i < npx; i++) begin
            logic [1:0] k;
            k = (i == npx - 1) ? KIND_FINAL : KIND_PIXEL;
            if ($urandom_range(0, 9) == 0)
                send_word(k, 8'($urandom), 8'($urandom), 8'($urandom), gaps);
            else
                send_word(k, 8'((b0 + $urandom_range(0, spread)) % 256),
                          8'((g0 + $urandom_range(0, spread)) % 256),
                          8'((r0 + $urandom_range(0, spread)) % 256), gaps);
        end
    endtask

    task automatic random_thresholds();
        for (int i = 0; i < NUM_REGS; i++) begin
            if (i < REG_WHITE_SAT_LIMIT)
                apb_write(reg_idx_t'(i), 8'($urandom_range(0, 179)));
            else
                apb_write(reg_idx_t'(i), 8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        int sent;
        sb = new();
        sb.init();
        long_stall = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_kind = KIND_PIXEL;
        s_blue = '0; s_green = '0; s_red = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: extremes, every kind, special cases
        send_word(KIND_FINAL, 8'd0, 8'd0, 8'd0, 0);
        send_word(KIND_FINAL, 8'd255, 8'd255, 8'd255, 0);
        send_word(KIND_FINAL, 8'd0, 8'd0, 8'd255, 0);
        send_word(KIND_FINAL, 8'd0, 8'd255, 8'd0, 0);
        send_word(KIND_FINAL, 8'd255, 8'd0, 8'd0, 0);
        send_word(KIND_FINAL, 8'd0, 8'd128, 8'd255, 0);
        send_word(KIND_FINAL, 8'd0, 8'd255, 8'd255, 0);
        send_word(KIND_FINAL, 8'd1, 8'd0, 8'd255, 0);   // hue wraps to zero
        send_word(KIND_FINAL, 8'd200, 8'd180, 8'd190, 0);
        send_word(KIND_EMPTY, 8'd0, 8'd0, 8'd0, 0);
        send_word(KIND_PIXEL, 8'd10, 8'd20, 8'd30, 0);
        send_word(KIND_PIXEL, 8'd90, 8'd20, 8'd30, 0);
        send_word(KIND_EMPTY, 8'd255, 8'd255, 8'd255, 0); // drops counted pixels
        send_word(KIND_UNUSED, 8'd255, 8'd255, 8'd255, 0);
        send_word(KIND_PIXEL, 8'd0, 8'd255, 8'd0, 0);
        send_word(KIND_FINAL, 8'd255, 8'd0, 8'd0, 0);
        drain();

        // threshold extremes
        for (int i = 0; i < NUM_REGS; i++) apb_write(reg_idx_t'(i), 8'd0);
        send_patch(3, 0);
        send_word(KIND_FINAL, 8'd0, 8'd0, 8'd255, 0);
        drain();
        for (int i = 0; i < NUM_REGS; i++)
            apb_write(reg_idx_t'(i), (i < REG_WHITE_SAT_LIMIT) ? 8'd179 : 8'd255);
        send_patch(3, 0);
        send_word(KIND_FINAL, 8'd0, 8'd255, 8'd0, 0);
        drain();
        for (int i = 0; i < NUM_REGS; i++)
            apb_write(reg_idx_t'(i), reg_reset_value(reg_idx_t'(i)));

        // random phases
        sent = 0;
        for (int ph = 0; ph < 4; ph++) begin
            if (ph == 2) long_stall = 1'b1;
            while (sent < (ph + 1) * 500) begin
                int r;
                r = $urandom_range(0, 19);
                if (r == 0) begin
                    send_word(KIND_EMPTY, 8'($urandom), 8'($urandom), 8'($urandom), 1);
                    sent++;
                end else if (r == 1) begin
                    send_word(KIND_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom), 1);
                end else begin
                    int n;
                    n = $urandom_range(1, 25);
                    send_patch(n, ph != 2);
                    sent += n;
                end
            end
            drain();
            if (ph < 3) random_thresholds();
        end

        end_word();
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
